[rtl/tpsc_pkg.sv]
// Package for the three-prime sum counter: sizes, micro-op and condition codes,
// the control word and status types, and the microprogram ROM.
// No dependencies.
package tpsc_pkg;

    localparam int LIMIT       = 1024;
    localparam int PRIME_SLOTS = 256;

    localparam int TGT_W      = 12;
    localparam int CNT_OUT_W  = 14;
    localparam int VAL_W      = $clog2(LIMIT + 1);
    localparam int FLAG_DEPTH = LIMIT + 1;
    localparam int SLOT_AW    = $clog2(PRIME_SLOTS);
    localparam int CNT_W      = $clog2(PRIME_SLOTS + 1);
    localparam int CMP_W      = ((VAL_W > TGT_W) ? VAL_W : TGT_W) + 2;
    localparam int PC_W       = 5;

    localparam logic [CNT_OUT_W-1:0] COUNT_MAX = {CNT_OUT_W{1'b1}};

    typedef logic [4:0] op_t;

    localparam op_t OP_NOP       = 5'd0;
    localparam op_t OP_CLR_I     = 5'd1;
    localparam op_t OP_FILL      = 5'd2;
    localparam op_t OP_SET_I2    = 5'd3;
    localparam op_t OP_SIEVE_RD  = 5'd4;
    localparam op_t OP_MARK      = 5'd5;
    localparam op_t OP_INC_I     = 5'd6;
    localparam op_t OP_LIST_INIT = 5'd7;
    localparam op_t OP_LIST_RD   = 5'd8;
    localparam op_t OP_LIST_PUT  = 5'd9;
    localparam op_t OP_IDLE      = 5'd10;
    localparam op_t OP_Q_INIT    = 5'd11;
    localparam op_t OP_RD_P      = 5'd12;
    localparam op_t OP_LATCH_P   = 5'd13;
    localparam op_t OP_RD_Q      = 5'd14;
    localparam op_t OP_TEST_Q    = 5'd15;
    localparam op_t OP_RD_R      = 5'd16;
    localparam op_t OP_COUNT     = 5'd17;
    localparam op_t OP_NEXT_A    = 5'd18;
    localparam op_t OP_EMIT      = 5'd19;

    typedef logic [3:0] cond_t;

    localparam cond_t C_NEVER      = 4'd0;
    localparam cond_t C_ALWAYS     = 4'd1;
    localparam cond_t C_I_NOT_LAST = 4'd2;
    localparam cond_t C_SQ_OVER    = 4'd3;
    localparam cond_t C_FLAG_ZERO  = 4'd4;
    localparam cond_t C_J_NEXT_OK  = 4'd5;
    localparam cond_t C_NO_START   = 4'd6;
    localparam cond_t C_A_END      = 4'd7;
    localparam cond_t C_P_STOP     = 4'd8;
    localparam cond_t C_B_END      = 4'd9;
    localparam cond_t C_Q_STOP     = 4'd10;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_CLR     = 5'd0;
    localparam pc_t PC_FILL    = 5'd1;
    localparam pc_t PC_SET_I2  = 5'd2;
    localparam pc_t PC_SIEVE   = 5'd3;
    localparam pc_t PC_TEST_F  = 5'd4;
    localparam pc_t PC_MARK    = 5'd5;
    localparam pc_t PC_NEXT_I  = 5'd6;
    localparam pc_t PC_LIST    = 5'd7;
    localparam pc_t PC_LIST_RD = 5'd8;
    localparam pc_t PC_PUT     = 5'd9;
    localparam pc_t PC_IDLE    = 5'd10;
    localparam pc_t PC_Q_INIT  = 5'd11;
    localparam pc_t PC_P       = 5'd12;
    localparam pc_t PC_LATCH_P = 5'd13;
    localparam pc_t PC_Q       = 5'd14;
    localparam pc_t PC_TEST_Q  = 5'd15;
    localparam pc_t PC_RD_R    = 5'd16;
    localparam pc_t PC_COUNT   = 5'd17;
    localparam pc_t PC_NEXT_A  = 5'd18;
    localparam pc_t PC_EMIT    = 5'd19;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   tgt;
    } uword_t;

    typedef struct packed {
        logic i_not_last;
        logic sq_over;
        logic flag_zero;
        logic j_next_ok;
        logic a_end;
        logic p_stop;
        logic b_end;
        logic q_stop;
    } stat_t;

    // When the condition holds the sequencer jumps to tgt, otherwise it steps on.
    function automatic uword_t ucode(input pc_t pc);
        uword_t u;
        case (pc)
            PC_CLR:     u = '{OP_CLR_I,     C_NEVER,      PC_CLR};
            PC_FILL:    u = '{OP_FILL,      C_I_NOT_LAST, PC_FILL};
            PC_SET_I2:  u = '{OP_SET_I2,    C_NEVER,      PC_CLR};
            PC_SIEVE:   u = '{OP_SIEVE_RD,  C_SQ_OVER,    PC_LIST};
            PC_TEST_F:  u = '{OP_NOP,       C_FLAG_ZERO,  PC_NEXT_I};
            PC_MARK:    u = '{OP_MARK,      C_J_NEXT_OK,  PC_MARK};
            PC_NEXT_I:  u = '{OP_INC_I,     C_ALWAYS,     PC_SIEVE};
            PC_LIST:    u = '{OP_LIST_INIT, C_NEVER,      PC_CLR};
            PC_LIST_RD: u = '{OP_LIST_RD,   C_NEVER,      PC_CLR};
            PC_PUT:     u = '{OP_LIST_PUT,  C_I_NOT_LAST, PC_LIST_RD};
            PC_IDLE:    u = '{OP_IDLE,      C_NO_START,   PC_IDLE};
            PC_Q_INIT:  u = '{OP_Q_INIT,    C_NEVER,      PC_CLR};
            PC_P:       u = '{OP_RD_P,      C_A_END,      PC_EMIT};
            PC_LATCH_P: u = '{OP_LATCH_P,   C_P_STOP,     PC_EMIT};
            PC_Q:       u = '{OP_RD_Q,      C_B_END,      PC_NEXT_A};
            PC_TEST_Q:  u = '{OP_TEST_Q,    C_Q_STOP,     PC_NEXT_A};
            PC_RD_R:    u = '{OP_RD_R,      C_NEVER,      PC_CLR};
            PC_COUNT:   u = '{OP_COUNT,     C_ALWAYS,     PC_Q};
            PC_NEXT_A:  u = '{OP_NEXT_A,    C_ALWAYS,     PC_P};
            PC_EMIT:    u = '{OP_EMIT,      C_ALWAYS,     PC_IDLE};
            default:    u = '{OP_NOP,       C_ALWAYS,     PC_CLR};
        endcase
        return u;
    endfunction

endpackage

[rtl/tpsc_useq.sv]
// Microcode sequencer: step counter, program ROM lookup and jump resolution.
// Depends on tpsc_pkg.
module tpsc_useq
    import tpsc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output op_t   op,
    output logic  busy
);

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t uw;
    logic   take;

    assign uw   = ucode(pc_reg);
    assign op   = uw.op;
    assign busy = (pc_reg != PC_IDLE);

    always_comb
    begin
        case (uw.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_I_NOT_LAST: take = stat.i_not_last;
            C_SQ_OVER:    take = stat.sq_over;
            C_FLAG_ZERO:  take = stat.flag_zero;
            C_J_NEXT_OK:  take = stat.j_next_ok;
            C_NO_START:   take = !start;
            C_A_END:      take = stat.a_end;
            C_P_STOP:     take = stat.p_stop;
            C_B_END:      take = stat.b_end;
            C_Q_STOP:     take = stat.q_stop;
            default:      take = 1'b0;
        endcase
        pc_next = take ? uw.tgt : pc_reg + pc_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_CLR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[rtl/tpsc_dpath.sv]
// Datapath: prime flag memory, prime list memory, sieve and search counters,
// comparators and the saturating triple counter, driven by one micro-op a cycle.
// Depends on tpsc_pkg.
module tpsc_dpath
    import tpsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  op_t                  op,
    input  logic                 start,
    input  logic [TGT_W-1:0]     target_sum,
    output stat_t                stat,
    output logic                 done,
    output logic [CNT_OUT_W-1:0] triple_count
);

    logic flag_mem [FLAG_DEPTH];
    logic [VAL_W-1:0] list_mem [PRIME_SLOTS];

    logic                 flag_q;
    logic [VAL_W-1:0]     list_q;

    logic [VAL_W-1:0]     i_reg, i_next;
    logic [VAL_W-1:0]     j_reg, j_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]     a_reg, a_next;
    logic [CNT_W-1:0]     b_reg, b_next;
    logic [CNT_OUT_W-1:0] count_reg, count_next;
    logic [TGT_W-1:0]     target_reg, target_next;
    logic [TGT_W-1:0]     rest_reg, rest_next;
    logic [TGT_W-1:0]     r_reg, r_next;

    logic [2*VAL_W-1:0]   sq;
    logic [VAL_W:0]       j_sum;
    logic [CMP_W-1:0]     list_ext, tgt_ext, rest_ext, r_ext, rest_full, r_full;
    logic                 r_ok;

    logic                 flag_we, flag_wdata, flag_re;
    logic [VAL_W-1:0]     flag_waddr, flag_raddr;
    logic                 list_we, list_re;
    logic [SLOT_AW-1:0]   list_raddr;

    assign sq        = i_reg * i_reg;
    assign j_sum     = {1'b0, j_reg} + {1'b0, i_reg};
    assign list_ext  = CMP_W'(list_q);
    assign tgt_ext   = CMP_W'(target_reg);
    assign rest_ext  = CMP_W'(rest_reg);
    assign r_ext     = CMP_W'(r_reg);
    assign rest_full = tgt_ext - list_ext;
    assign r_full    = rest_ext - list_ext;
    assign r_ok      = (r_ext <= CMP_W'(LIMIT));

    assign stat.i_not_last = (i_reg != VAL_W'(LIMIT));
    assign stat.sq_over    = (sq > (2*VAL_W)'(LIMIT));
    assign stat.flag_zero  = !flag_q;
    assign stat.j_next_ok  = (j_sum <= (VAL_W+1)'(LIMIT));
    assign stat.a_end      = (a_reg >= total_reg);
    assign stat.p_stop     = ((list_ext + {list_ext[CMP_W-2:0], 1'b0}) >= tgt_ext);
    assign stat.b_end      = (b_reg >= total_reg);
    assign stat.q_stop     = ({list_ext[CMP_W-2:0], 1'b0} >= rest_ext);

    assign done         = (op == OP_EMIT);
    assign triple_count = count_reg;

    always_comb
    begin
        flag_we     = 1'b0;
        flag_wdata  = 1'b0;
        flag_waddr  = i_reg;
        flag_re     = 1'b0;
        flag_raddr  = i_reg;
        list_we     = 1'b0;
        list_re     = 1'b0;
        list_raddr  = a_reg[SLOT_AW-1:0];
        i_next      = i_reg;
        j_next      = j_reg;
        total_next  = total_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        count_next  = count_reg;
        target_next = target_reg;
        rest_next   = rest_reg;
        r_next      = r_reg;
        case (op)
            OP_CLR_I:
            begin
                i_next = '0;
            end
            OP_FILL:
            begin
                flag_we    = 1'b1;
                flag_wdata = (i_reg >= VAL_W'(2));
                i_next     = i_reg + VAL_W'(1);
            end
            OP_SET_I2:
            begin
                i_next = VAL_W'(2);
            end
            OP_SIEVE_RD:
            begin
                flag_re = 1'b1;
                j_next  = sq[VAL_W-1:0];
            end
            OP_MARK:
            begin
                flag_we    = 1'b1;
                flag_waddr = j_reg;
                j_next     = j_sum[VAL_W-1:0];
            end
            OP_INC_I:
            begin
                i_next = i_reg + VAL_W'(1);
            end
            OP_LIST_INIT:
            begin
                i_next     = VAL_W'(2);
                total_next = '0;
            end
            OP_LIST_RD:
            begin
                flag_re = 1'b1;
            end
            OP_LIST_PUT:
            begin
                list_we = flag_q && (total_reg < CNT_W'(PRIME_SLOTS));
                if (list_we)
                begin
                    total_next = total_reg + CNT_W'(1);
                end
                i_next = i_reg + VAL_W'(1);
            end
            OP_IDLE:
            begin
                if (start)
                begin
                    target_next = target_sum;
                end
            end
            OP_Q_INIT:
            begin
                a_next     = '0;
                count_next = '0;
            end
            OP_RD_P:
            begin
                list_re    = !stat.a_end;
                list_raddr = a_reg[SLOT_AW-1:0];
            end
            OP_LATCH_P:
            begin
                b_next    = a_reg + CNT_W'(1);
                rest_next = rest_full[TGT_W-1:0];
            end
            OP_RD_Q:
            begin
                list_re    = !stat.b_end;
                list_raddr = b_reg[SLOT_AW-1:0];
            end
            OP_TEST_Q:
            begin
                r_next = r_full[TGT_W-1:0];
            end
            OP_RD_R:
            begin
                flag_re    = r_ok;
                flag_raddr = r_ext[VAL_W-1:0];
                b_next     = b_reg + CNT_W'(1);
            end
            OP_COUNT:
            begin
                if (r_ok && flag_q && (count_reg != COUNT_MAX))
                begin
                    count_next = count_reg + CNT_OUT_W'(1);
                end
            end
            OP_NEXT_A:
            begin
                a_next = a_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
        if (flag_re)
        begin
            flag_q <= flag_mem[flag_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[total_reg[SLOT_AW-1:0]] <= i_reg;
        end
        if (list_re)
        begin
            list_q <= list_mem[list_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg     <= '0;
            j_reg     <= '0;
            total_reg <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            count_reg <= '0;
        end
        else
        begin
            i_reg     <= i_next;
            j_reg     <= j_next;
            total_reg <= total_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        rest_reg   <= rest_next;
        r_reg      <= r_next;
    end

endmodule

[rtl/three_prime_sum_counter.sv]
// Three-prime sum counter: for each target word, counts the prime triples
// p < q < r that sum to it. Depends on tpsc_pkg, tpsc_useq and tpsc_dpath.
//
// A word is taken when start is high and busy is low; target_sum is sampled
// then. The result appears on triple_count for exactly one cycle with done
// high, and the receiver must take it in that cycle; it cannot stall.
// busy stays high from the accepting edge until the cycle after done.
// After reset the block is busy while the program sieves the flag memory up
// to LIMIT (presetting every entry, then crossing out each multiple) and
// then builds the ordered prime list (a flag read and a list write per value).
// A query reads and latches each p value, runs the q loop and steps to the
// next p; each (p, q) candidate pair takes a list read for q, a test, a flag
// read for the remainder and a count, and the q loop ends on a q read or
// test. Setup comes first and the output last. At the largest targets every
// pair of listed primes is tried.
// The inner loop is bounded by the single read port of each memory:
// one list read for q, then one flag read for the remainder.
// Only one word is in flight at a time; the next is taken once busy drops.
module three_prime_sum_counter
    import tpsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [TGT_W-1:0]     target_sum,
    output logic                 done,
    output logic [CNT_OUT_W-1:0] triple_count
);

    op_t   op;
    stat_t stat;

    tpsc_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy)
    );

    tpsc_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .start        (start),
        .target_sum   (target_sum),
        .stat         (stat),
        .done         (done),
        .triple_count (triple_count)
    );

    // A result is only shown while the block is working on a word.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done raised while not busy");

    // The block is ready again right after it delivers a result.
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("block not ready after result");

    // An accepted word keeps the block busy and gives no result in the next cycle.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not start a search");

endmodule

[test/tb_three_prime_sum_counter.sv]
// Testbench for three_prime_sum_counter: directed and random target words, each count checked
// against a table value or a sieve-based triple counter kept in the testbench.
// Depends on tpsc_pkg and the three_prime_sum_counter RTL.
module tb_three_prime_sum_counter;
    import tpsc_pkg::*;

    typedef struct {
        logic [TGT_W-1:0]     target;
        bit                   known;
        logic [CNT_OUT_W-1:0] count;
    } target_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [TGT_W-1:0]     target_sum;
    logic                 done;
    logic [CNT_OUT_W-1:0] triple_count;

    bit                   sieve_flag [0:LIMIT];
    int unsigned          prime_seq [PRIME_SLOTS];
    int unsigned          prime_cnt;
    logic [CNT_OUT_W-1:0] pending_counts [$];
    int unsigned          fail_cnt;

    three_prime_sum_counter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .target_sum   (target_sum),
        .done         (done),
        .triple_count (triple_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(64'd300_000_000);
        $display("Test completed with failures");
        $finish;
    end

    function automatic void build_prime_tables();
        for (int v = 0; v <= LIMIT; v++)
            sieve_flag[v] = (v >= 2);
        for (int i = 2; i * i <= LIMIT; i++)
            if (sieve_flag[i])
                for (int j = i * i; j <= LIMIT; j += i)
                    sieve_flag[j] = 1'b0;
        prime_cnt = 0;
        for (int v = 2; v <= LIMIT; v++)
            if (sieve_flag[v] && prime_cnt < PRIME_SLOTS)
            begin
                prime_seq[prime_cnt] = v;
                prime_cnt++;
            end
    endfunction

    function automatic logic [CNT_OUT_W-1:0] count_triples(input logic [TGT_W-1:0] tgt);
        int unsigned sum_val;
        int unsigned rest;
        int unsigned p;
        int unsigned q;
        int unsigned r;
        int unsigned total;
        sum_val = tgt;
        total = 0;
        for (int a = 0; a < prime_cnt; a++)
        begin
            p = prime_seq[a];
            if (3 * p >= sum_val)
                break;
            rest = sum_val - p;
            for (int b = a + 1; b < prime_cnt; b++)
            begin
                q = prime_seq[b];
                if (2 * q >= rest)
                    break;
                r = rest - q;
                if (r > q && r <= LIMIT && sieve_flag[r] && total < COUNT_MAX)
                    total++;
            end
        end
        return total[CNT_OUT_W-1:0];
    endfunction

    // Most targets stay small so that the run stays short; a few span the full word.
    function automatic logic [TGT_W-1:0] pick_target();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 4)
            return TGT_W'($urandom_range((1 << TGT_W) - 1));
        else if (sel < 16)
            return TGT_W'($urandom_range(40));
        else
            return TGT_W'($urandom_range(1100));
    endfunction

    task automatic send_target(input target_row_t row, input int unsigned idle_pct);
        target_sum <= row.target;
        forever
        begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge clk);
            if (start === 1'b1 && busy === 1'b0)
                break;
        end
        pending_counts.push_back(row.known ? row.count : count_triples(row.target));
    endtask

    task automatic wait_for_counts();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_counts.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (done === 1'b1)
        begin
            if (pending_counts.size() == 0)
            begin
                $display("%0t: triple_count %0d arrived with no word outstanding",
                         $time, triple_count);
                fail_cnt++;
            end
            else
            begin
                logic [CNT_OUT_W-1:0] want;
                want = pending_counts.pop_front();
                if (triple_count !== want)
                begin
                    $display("%0t: triple_count mismatch: expected %0d, actual %0d",
                             $time, want, triple_count);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        target_row_t directed [18] = '{
            '{12'd0,    1'b1, 14'd0},
            '{12'd1,    1'b1, 14'd0},
            '{12'd9,    1'b1, 14'd0},
            '{12'd10,   1'b1, 14'd1},
            '{12'd11,   1'b1, 14'd0},
            '{12'd12,   1'b1, 14'd1},
            '{12'd15,   1'b1, 14'd1},
            '{12'd16,   1'b0, 14'd0},
            '{12'd17,   1'b0, 14'd0},
            '{12'd100,  1'b0, 14'd0},
            '{12'd101,  1'b0, 14'd0},
            '{12'd682,  1'b0, 14'd0},
            '{12'd1024, 1'b0, 14'd0},
            '{12'd1025, 1'b0, 14'd0},
            '{12'd1365, 1'b0, 14'd0},
            '{12'd2047, 1'b0, 14'd0},
            '{12'd2048, 1'b0, 14'd0},
            '{12'd4095, 1'b0, 14'd0}
        };
        int unsigned idle_plan [3] = '{9, 68, 0};
        target_row_t row;

        fail_cnt = 0;
        rst_n = 1'b0;
        start = 1'b0;
        target_sum = '0;
        build_prime_tables();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_target(directed[i], 9);
        wait_for_counts();

        foreach (idle_plan[ph])
        begin
            for (int n = 0; n < 28; n++)
            begin
                row.target = pick_target();
                row.known = 1'b0;
                row.count = '0;
                send_target(row, idle_plan[ph]);
                if (n == 17)
                    wait_for_counts();
            end
        end

        wait_for_counts();
        repeat (100) @(posedge clk);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
rtl/tpsc_pkg.sv
rtl/tpsc_useq.sv
rtl/tpsc_dpath.sv
rtl/three_prime_sum_counter.sv
test/tb_three_prime_sum_counter.sv
